FILE: rtl/hrl_pkg.sv
// shared types and codes for the hex record loader
`default_nettype none

package hrl_pkg;

    localparam int unsigned ADDR_W = 17;
    localparam int unsigned QUEUE_DEPTH = 2;

    // input beat: one character or an end-of-file mark
    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in;

    // result kinds
    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_TRANSFER = 2'd1,
        KIND_ERROR    = 2'd2,
        KIND_END      = 2'd3
    } t_kind;

    // result beat
    typedef struct packed {
        t_kind             kind;
        logic [ADDR_W-1:0] address;
        logic [7:0]        value;
    } t_out;

    // classified character handed from front to back
    typedef struct packed {
        logic       eoi;
        logic       is_newline;
        logic       is_colon;
        logic       is_hex;
        logic [3:0] digit;
    } t_token;

endpackage

`default_nettype wire

FILE: rtl/hrl_front.sv
// front end: classifies each character beat into a token
`default_nettype none

module hrl_front (
    input  wire hrl_pkg::t_in    i_in,
    output hrl_pkg::t_token      o_token
);
    import hrl_pkg::*;

    logic [7:0] c;

    // hex digit decode and line markers
    always_comb begin
        c = i_in.char_code;
        o_token.eoi        = i_in.end_of_input;
        o_token.is_newline = (c == 8'h0a);
        o_token.is_colon   = (c == 8'h3a);
        o_token.is_hex     = 1'b0;
        o_token.digit      = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            o_token.is_hex = 1'b1;
            o_token.digit  = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            o_token.is_hex = 1'b1;
            o_token.digit  = 4'(c - 8'h37);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            o_token.is_hex = 1'b1;
            o_token.digit  = 4'(c - 8'h57);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hrl_queue.sv
// two-entry token queue between front and back
`default_nettype none

module hrl_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire hrl_pkg::t_token i_token,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_valid,
    output hrl_pkg::t_token      o_token
);
    import hrl_pkg::*;

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;
    logic [CNT_W-1:0]   n_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd];

    // pointer and fill count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_token;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hrl_back.sv
// back end: record parser state machine and result register
`default_nettype none

module hrl_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_tok_valid,
    input  wire hrl_pkg::t_token i_token,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output hrl_pkg::t_out        o_out
);
    import hrl_pkg::*;

    typedef enum logic [13:0] {
        PH_LINE_START = 14'b00000000000001,
        PH_SKIP       = 14'b00000000000010,
        PH_COUNT_A    = 14'b00000000000100,
        PH_COUNT_B    = 14'b00000000001000,
        PH_AHI_A      = 14'b00000000010000,
        PH_AHI_B      = 14'b00000000100000,
        PH_ALO_A      = 14'b00000001000000,
        PH_ALO_B      = 14'b00000010000000,
        PH_TYPE_A     = 14'b00000100000000,
        PH_TYPE_B     = 14'b00001000000000,
        PH_DATA_A     = 14'b00010000000000,
        PH_DATA_B     = 14'b00100000000000,
        PH_SUM_A      = 14'b01000000000000,
        PH_SUM_B      = 14'b10000000000000
    } t_phase;

    t_phase            r_phase,    n_phase;
    logic [3:0]        r_first,    n_first;
    logic              r_first_ok, n_first_ok;
    logic [7:0]        r_left,     n_left;
    logic [ADDR_W-1:0] r_addr,     n_addr;
    logic [7:0]        r_sum,      n_sum;
    logic [ADDR_W-1:0] r_high,     n_high;
    logic              r_halted,   n_halted;
    logic              r_out_valid, n_out_valid;
    t_out              r_out,      n_out;

    logic              emit;
    t_out              res;
    logic [7:0]        pair;
    logic [7:0]        left_dec;
    logic [ADDR_W-1:0] addr_inc;

    assign o_pop       = i_tok_valid && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // second digit of a pair joined with the stored first digit
    always_comb begin
        if (!r_first_ok) begin
            pair = 8'd0;
        end else if (i_token.is_hex) begin
            pair = {r_first, i_token.digit};
        end else begin
            pair = {4'd0, r_first};
        end
    end

    assign left_dec = r_left - 8'd1;
    assign addr_inc = r_addr + ADDR_W'(1);

    // parser step for one token
    always_comb begin
        n_phase    = r_phase;
        n_first    = r_first;
        n_first_ok = r_first_ok;
        n_left     = r_left;
        n_addr     = r_addr;
        n_sum      = r_sum;
        n_high     = r_high;
        n_halted   = r_halted;
        emit       = 1'b0;
        res        = '{kind: KIND_DATA, address: '0, value: 8'd0};
        if (o_pop && !r_halted) begin
            if (i_token.eoi) begin
                n_phase    = PH_LINE_START;
                n_first_ok = 1'b0;
                emit       = 1'b1;
                res        = '{kind: KIND_END, address: r_high, value: 8'd0};
            end else if (i_token.is_newline) begin
                n_phase = PH_LINE_START;
            end else begin
                case (r_phase)
                    PH_LINE_START: begin
                        n_phase = i_token.is_colon ? PH_COUNT_A : PH_SKIP;
                    end
                    PH_COUNT_A, PH_AHI_A, PH_ALO_A, PH_TYPE_A, PH_DATA_A, PH_SUM_A: begin
                        n_first_ok = i_token.is_hex;
                        n_first    = i_token.digit;
                        n_phase    = t_phase'({r_phase[12:0], 1'b0});
                    end
                    PH_COUNT_B: begin
                        n_left  = pair;
                        n_sum   = pair;
                        n_phase = PH_AHI_A;
                    end
                    PH_AHI_B: begin
                        n_addr  = {1'b0, pair, 8'd0};
                        n_sum   = r_sum + pair;
                        n_phase = PH_ALO_A;
                    end
                    PH_ALO_B: begin
                        n_addr  = r_addr | {9'd0, pair};
                        n_sum   = r_sum + pair;
                        n_phase = PH_TYPE_A;
                    end
                    PH_TYPE_B: begin
                        if (r_left == 8'd0) begin
                            n_phase = PH_SKIP;
                            emit    = 1'b1;
                            res     = '{kind: KIND_TRANSFER,
                                        address: {1'b0, r_addr[15:0]}, value: 8'd0};
                        end else begin
                            n_phase = PH_DATA_A;
                        end
                    end
                    PH_DATA_B: begin
                        n_sum  = r_sum + pair;
                        n_addr = addr_inc;
                        n_left = left_dec;
                        emit   = 1'b1;
                        res    = '{kind: KIND_DATA, address: r_addr, value: pair};
                        if (left_dec == 8'd0) begin
                            if (addr_inc > r_high) begin
                                n_high = addr_inc;
                            end
                            n_phase = PH_SUM_A;
                        end else begin
                            n_phase = PH_DATA_A;
                        end
                    end
                    PH_SUM_B: begin
                        n_phase = PH_SKIP;
                        if ((8'd0 - r_sum) != pair) begin
                            n_halted = 1'b1;
                            emit     = 1'b1;
                            res      = '{kind: KIND_ERROR, address: '0, value: 8'd0};
                        end
                    end
                    default: begin
                        n_phase = PH_SKIP;
                    end
                endcase
            end
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LINE_START;
            r_first     <= 4'd0;
            r_first_ok  <= 1'b0;
            r_left      <= 8'd0;
            r_addr      <= '0;
            r_sum       <= 8'd0;
            r_high      <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_first     <= n_first;
            r_first_ok  <= n_first_ok;
            r_left      <= n_left;
            r_addr      <= n_addr;
            r_sum       <= n_sum;
            r_high      <= n_high;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

`default_nettype wire

FILE: rtl/hex_record_loader.sv
// Hex record loader: one character beat per cycle in unless stalled, zero or
// one result beat out; each result is registered. Throughput: one beat per cycle
// unless stalled; a two-entry token queue separates the character classifier
// from the record parser, so each side stalls on its own.
// Reset: synchronous active-low; parser returns to line start, high mark cleared.
`default_nettype none

module hex_record_loader (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  wire hrl_pkg::t_in   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output hrl_pkg::t_out       o_out
);
    import hrl_pkg::*;

    t_token front_tok;
    t_token queue_tok;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign o_in_stall = q_full;

    // character classification
    hrl_front u_front (
        .i_in    (i_in),
        .o_token (front_tok)
    );

    // decoupling queue
    hrl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && !q_full),
        .i_token (front_tok),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_token (queue_tok)
    );

    // record parser
    hrl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok_valid (q_valid),
        .i_token     (queue_tok),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

FILE: rtl/hrl_checker.sv
// port-level checks for the hex record loader, bound to the top level
`default_nettype none

module hrl_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 o_in_stall,
    input  wire hrl_pkg::t_in   i_in,
    input  wire                 o_out_valid,
    input  wire                 i_out_stall,
    input  wire hrl_pkg::t_out  o_out
);
    import hrl_pkg::*;

    // result beat held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat dropped or changed under stall");

    // no result beat directly follows an accepted checksum error
    a_error_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && o_out.kind == KIND_ERROR |=> !o_out_valid)
        else $error("result after checksum error");

    // only data beats carry a value
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.kind != KIND_DATA |-> o_out.value == 8'd0)
        else $error("nonzero value on non-data beat");

    // transfer and error addresses fit in 16 bits
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.kind == KIND_TRANSFER || o_out.kind == KIND_ERROR)
        |-> !o_out.address[16])
        else $error("address out of range for kind");

    // reset empties both sides
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs active after reset");

endmodule

bind hex_record_loader hrl_checker u_hrl_checker (.*);

`default_nettype wire
